// File: sv/ray_sphere_closest_hit_top_defines.svh
// Assertion macros for the ray/sphere closest-hit block.
// RSCH_ASSERT is gated by reset; RSCH_ASSERT_NR also checks while reset is held.
`ifndef RAY_SPHERE_CLOSEST_HIT_TOP_DEFINES_SVH
`define RAY_SPHERE_CLOSEST_HIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RSCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RSCH_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RSCH_ASSERT(lbl, prop, msg)
`define RSCH_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// File: sv/rsch_pkg.sv
`timescale 1ns / 1ps

package rsch_pkg;

  localparam int MAX_SPHERES_DEF = 64;

  localparam int CNT_W     = 7;   // sphere_count register
  localparam int TLIM_W    = 31;  // t limits, hit_t
  localparam int CRD_W     = 32;  // coordinates
  localparam int RAD_W     = 31;  // radius
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 31;

  localparam logic [TLIM_W-1:0] NEAR_RESET = 31'd66;
  localparam logic [TLIM_W-1:0] FAR_RESET  = 31'h7FFF_FFFF;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RAY  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT = 2'd0,
    REG_NEAR  = 2'd1,
    REG_FAR   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] cz;
    logic [RAD_W-1:0]        rad;
  } sphere_t;

endpackage

// File: sv/ray_sphere_closest_hit_top.sv
// Channel | Direction | Handshake                    | Word
// cfg     | in        | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o      | mode, slot, pos, dir, radius
// out     | out       | out_valid_o / out_ready_i    | hit, slot, t, point, normal
//
// A load word is a table write. A ray word walks the table one slot at a
// time through a shared sequencer: a normalizing shift loop, 31 square-root steps
// and a 48-step divide per tried root, with a zero-radius slot skipped after its
// read; a hit adds the point and a divide per normal axis. The sqrt and divide
// loops dominate the run time.
// Reset is asynchronous, active low; the sphere table is not cleared.
// The output register lets a new word in while a result waits; a ray stalls only
// at its final step until the output register is free.
`timescale 1ns / 1ps
`include "ray_sphere_closest_hit_top_defines.svh"

module ray_sphere_closest_hit_top #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsch_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsch_pkg::CFG_DAT_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [rsch_pkg::SLOT_W-1:0]         slot_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   pos_x_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   pos_y_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   pos_z_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   dir_x_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   dir_y_i,
  input  logic signed [rsch_pkg::CRD_W-1:0]   dir_z_i,
  input  logic [rsch_pkg::RAD_W-1:0]          sphere_radius_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [rsch_pkg::SLOT_W-1:0]         hit_slot_o,
  output logic [rsch_pkg::TLIM_W-1:0]         hit_t_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   point_x_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   point_y_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   point_z_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   normal_x_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   normal_y_o,
  output logic signed [rsch_pkg::CRD_W-1:0]   normal_z_o
);
  import rsch_pkg::*;

  localparam int AW     = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW     = (AW >= CNT_W) ? AW + 1 : CNT_W;
  localparam int DIV_W  = 48;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);
  localparam logic [61:0] SQ_TOP = 62'd1 << 60;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_RD    = 21'h000002,
    S_OC    = 21'h000004,
    S_PROD  = 21'h000008,
    S_SUM   = 21'h000010,
    S_MAG   = 21'h000020,
    S_MAXS  = 21'h000040,
    S_NORM  = 21'h000080,
    S_MULD  = 21'h000100,
    S_DSUB  = 21'h000200,
    S_SQRT  = 21'h000400,
    S_ROOT  = 21'h000800,
    S_DIV   = 21'h001000,
    S_CHK   = 21'h002000,
    S_NEXT  = 21'h004000,
    S_PMUL  = 21'h008000,
    S_PADD  = 21'h010000,
    S_NPREP = 21'h020000,
    S_NDIV  = 21'h040000,
    S_NFIX  = 21'h080000,
    S_OUT   = 21'h100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CNT_W-1:0]  count_q;
  logic [TLIM_W-1:0] near_q, far_q;

  // sphere table, registered read
  sphere_t mem_q [MAX_SPHERES];
  sphere_t sp_q;
  sphere_t bc_q;   // sphere of the closest hit so far

  // ray
  logic signed [CRD_W-1:0] org_q [3];
  logic signed [CRD_W-1:0] dir_q [3];
  logic [KW-1:0] kk_q, n_q, best_q;
  logic [TLIM_W-1:0] closest_q;
  logic any_q, far_root_q;

  // quadratic
  logic signed [32:0] oc_q [3];
  logic [59:0]        dd_q [3];
  logic signed [60:0] od_q [3];
  logic [60:0]        mm_q [3];
  logic [58:0]        rr_q;
  logic [61:0]        aq_q;
  logic signed [62:0] bq_q;
  logic signed [63:0] cq_q;
  logic [62:0]        mb_q, mc_q, mx_q;
  logic [60:0]        bb_q;
  logic signed [61:0] ac_q;

  // sqrt and divider
  logic [61:0] sv_q, sres_q, sbit_q;
  logic [DIV_W-1:0] dv_q;
  logic [RAD_W-1:0] rem_q, dsr_q;
  logic [DCNT_W-1:0] dcnt_q;

  // point and normal
  logic signed [63:0] pm_q [3];
  logic signed [CRD_W-1:0] pt_q [3];
  logic signed [CRD_W-1:0] nm_q [3];
  logic [1:0] nidx_q;
  logic neg_q;

  // output register
  logic out_valid_q;
  logic out_hit_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TLIM_W-1:0] out_t_q;
  logic signed [CRD_W-1:0] out_pt_q [3];
  logic signed [CRD_W-1:0] out_nm_q [3];

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic accept, out_free, is_ray;
  logic [KW-1:0] slot_ext, cnt_ext, n_start, kk_inc;
  logic signed [63:0] p_dd [3];
  logic signed [64:0] p_od [3];
  logic signed [65:0] p_mm [3];
  logic [61:0] p_rr;
  logic [61:0] a_sum;
  logic signed [62:0] b_sum;
  logic signed [63:0] c_sum;
  logic [62:0] mb, mc;
  logic [29:0] a_n;
  logic signed [30:0] b_n, c_n;
  logic signed [61:0] p_bb, p_ac;
  logic signed [62:0] disc;
  logic [61:0] tsum;
  logic signed [32:0] nb, qs, num;
  logic num_ok;
  logic [31:0] rsh, rsub;
  logic ge;
  logic t_hit;
  logic signed [63:0] p_pm [3];
  logic signed [48:0] psum [3];
  logic signed [CRD_W-1:0] psat [3];
  logic signed [CRD_W-1:0] ctr_sel, pt_sel, nfix;
  logic signed [32:0] df;
  logic [32:0] dm;

  assign accept   = in_valid_i && in_ready_o;
  assign is_ray   = (mode_i == MODE_RAY);
  assign out_free = !out_valid_q || out_ready_i;
  assign slot_ext = KW'(slot_i);
  assign cnt_ext  = KW'(count_q);
  assign n_start  = (cnt_ext > KW'(MAX_SPHERES)) ? KW'(MAX_SPHERES) : cnt_ext;
  assign kk_inc   = kk_q + KW'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_dd[i] = dir_q[i] * dir_q[i];
      p_od[i] = oc_q[i] * dir_q[i];
      p_mm[i] = oc_q[i] * oc_q[i];
      p_pm[i] = $signed({1'b0, closest_q}) * dir_q[i];
      psum[i] = 49'(org_q[i]) + 49'($signed(pm_q[i][63:16]));
      if (psum[i][48:31] != {18{psum[i][48]}}) begin
        psat[i] = psum[i][48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        psat[i] = psum[i][31:0];
      end
    end
  end

  assign p_rr  = sp_q.rad * sp_q.rad;
  assign a_sum = 62'(dd_q[0]) + 62'(dd_q[1]) + 62'(dd_q[2]);
  assign b_sum = 63'(od_q[0]) + 63'(od_q[1]) + 63'(od_q[2]);
  assign c_sum = $signed(64'(mm_q[0]) + 64'(mm_q[1]) + 64'(mm_q[2]) - 64'(rr_q));
  assign mb    = bq_q[62] ? 63'(-bq_q) : 63'(bq_q);
  assign mc    = cq_q[63] ? 63'(-cq_q) : cq_q[62:0];

  // scaled coefficients once the shift loop is done
  assign a_n  = aq_q[29:0];
  assign b_n  = $signed(bq_q[30:0]);
  assign c_n  = $signed(cq_q[30:0]);
  assign p_bb = b_n * b_n;
  assign p_ac = $signed({1'b0, a_n}) * c_n;
  assign disc = $signed({2'b00, bb_q}) - 63'(ac_q);
  assign tsum = sres_q + sbit_q;

  // root numerator: -b - q (near) or -b + q (far)
  assign nb     = -(33'(b_n));
  assign qs     = $signed({2'b00, sres_q[30:0]});
  assign num    = far_root_q ? (nb + qs) : (nb - qs);
  assign num_ok = !num[32] && (num != '0);

  // one restoring divide step
  assign rsh  = {rem_q, dv_q[DIV_W-1]};
  assign rsub = rsh - {1'b0, dsr_q};
  assign ge   = (rsh >= {1'b0, dsr_q});

  assign t_hit = (dv_q < DIV_W'(closest_q)) && (dv_q > DIV_W'(near_q));

  always_comb begin
    case (nidx_q)
      2'd0:    begin ctr_sel = bc_q.cx; pt_sel = pt_q[0]; end
      2'd1:    begin ctr_sel = bc_q.cy; pt_sel = pt_q[1]; end
      default: begin ctr_sel = bc_q.cz; pt_sel = pt_q[2]; end
    endcase
  end

  assign df = 33'(pt_sel) - 33'(ctr_sel);
  assign dm = df[32] ? 33'(-df) : 33'(df);

  // normal quotient with sign and saturation
  always_comb begin
    if (neg_q) begin
      nfix = (dv_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : $signed(32'(-dv_q));
    end else begin
      nfix = (dv_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dv_q[31:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_ray) begin
          state_d = (n_start == '0) ? S_OUT : S_RD;
        end
      end
      S_RD:   state_d = S_OC;
      S_OC:   state_d = (sp_q.rad == '0) ? S_NEXT : S_PROD;
      S_PROD: state_d = S_SUM;
      S_SUM:  state_d = S_MAG;
      S_MAG:  state_d = S_MAXS;
      S_MAXS: state_d = S_NORM;
      S_NORM: begin
        if (mx_q[62:30] == '0) state_d = S_MULD;
      end
      S_MULD: state_d = (a_n == '0) ? S_NEXT : S_DSUB;
      S_DSUB: state_d = (disc[62] || disc == '0) ? S_NEXT : S_SQRT;
      S_SQRT: begin
        if (sbit_q[0]) state_d = S_ROOT;
      end
      S_ROOT: begin
        if (num_ok) begin
          state_d = S_DIV;
        end else if (far_root_q) begin
          state_d = S_NEXT;
        end
      end
      S_DIV: begin
        if (dcnt_q == DIV_LAST) state_d = S_CHK;
      end
      S_CHK: begin
        if (t_hit || far_root_q) state_d = S_NEXT;
        else state_d = S_ROOT;
      end
      S_NEXT: begin
        if (kk_inc >= n_q) state_d = any_q ? S_PMUL : S_OUT;
        else state_d = S_RD;
      end
      S_PMUL:  state_d = S_PADD;
      S_PADD:  state_d = S_NPREP;
      S_NPREP: state_d = S_NDIV;
      S_NDIV: begin
        if (dcnt_q == DIV_LAST) state_d = S_NFIX;
      end
      S_NFIX:  state_d = (nidx_q == 2'd2) ? S_OUT : S_NPREP;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      near_q      <= NEAR_RESET;
      far_q       <= FAR_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
          REG_NEAR:  near_q  <= cfg_wdata_i;
          REG_FAR:   far_q   <= cfg_wdata_i;
          default:   ;
        endcase
      end
    end
  end

  // sphere table: one write port (loads), one registered read port (ray walk)
  always_ff @(posedge clk_i) begin
    if (accept && !is_ray && slot_ext < KW'(MAX_SPHERES)) begin
      mem_q[slot_ext[AW-1:0]] <= '{cx: pos_x_i, cy: pos_y_i, cz: pos_z_i,
                                   rad: sphere_radius_i};
    end
    if (state_q == S_RD) begin
      sp_q <= mem_q[kk_q[AW-1:0]];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_ray) begin
          org_q      <= '{pos_x_i, pos_y_i, pos_z_i};
          dir_q      <= '{dir_x_i, dir_y_i, dir_z_i};
          kk_q       <= '0;
          n_q        <= n_start;
          best_q     <= '0;
          closest_q  <= far_q;
          any_q      <= 1'b0;
        end
      end
      S_OC: begin
        oc_q[0] <= 33'(org_q[0]) - 33'(sp_q.cx);
        oc_q[1] <= 33'(org_q[1]) - 33'(sp_q.cy);
        oc_q[2] <= 33'(org_q[2]) - 33'(sp_q.cz);
      end
      S_PROD: begin
        for (int i = 0; i < 3; i++) begin
          dd_q[i] <= p_dd[i][62:3];
          od_q[i] <= p_od[i][63:3];
          mm_q[i] <= p_mm[i][63:3];
        end
        rr_q <= p_rr[61:3];
      end
      S_SUM: begin
        aq_q <= a_sum;
        bq_q <= b_sum;
        cq_q <= c_sum;
      end
      S_MAG: begin
        mb_q <= mb;
        mc_q <= mc;
      end
      S_MAXS: begin
        if (63'(aq_q) >= mb_q && 63'(aq_q) >= mc_q) mx_q <= 63'(aq_q);
        else if (mb_q >= mc_q) mx_q <= mb_q;
        else mx_q <= mc_q;
      end
      S_NORM: begin
        // one bit per cycle; floor shifts compose
        if (mx_q[62:30] != '0) begin
          mx_q <= mx_q >> 1;
          aq_q <= aq_q >> 1;
          bq_q <= bq_q >>> 1;
          cq_q <= cq_q >>> 1;
        end
      end
      S_MULD: begin
        bb_q <= p_bb[60:0];
        ac_q <= p_ac;
      end
      S_DSUB: begin
        sv_q       <= disc[61:0];
        sres_q     <= '0;
        sbit_q     <= SQ_TOP;
        far_root_q <= 1'b0;
      end
      S_SQRT: begin
        if (sv_q >= tsum) begin
          sv_q   <= sv_q - tsum;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      S_ROOT: begin
        if (num_ok) begin
          dv_q   <= {num[31:0], 16'h0000};
          rem_q  <= '0;
          dsr_q  <= {1'b0, a_n};
          dcnt_q <= '0;
        end else begin
          far_root_q <= 1'b1;
        end
      end
      S_DIV, S_NDIV: begin
        rem_q  <= ge ? rsub[30:0] : rsh[30:0];
        dv_q   <= {dv_q[DIV_W-2:0], ge};
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      S_CHK: begin
        if (t_hit) begin
          closest_q <= dv_q[TLIM_W-1:0];
          best_q    <= kk_q;
          bc_q      <= sp_q;
          any_q     <= 1'b1;
        end else begin
          far_root_q <= 1'b1;
        end
      end
      S_NEXT: begin
        kk_q <= kk_inc;
      end
      S_PMUL: begin
        pm_q   <= p_pm;
        nidx_q <= '0;
      end
      S_PADD: begin
        pt_q <= psat;
      end
      S_NPREP: begin
        neg_q  <= df[32];
        dv_q   <= {dm[31:0], 16'h0000};
        rem_q  <= '0;
        dsr_q  <= bc_q.rad;
        dcnt_q <= '0;
      end
      S_NFIX: begin
        nm_q[nidx_q] <= nfix;
        nidx_q       <= nidx_q + 2'd1;
      end
      S_OUT: begin
        if (out_free) begin
          out_hit_q  <= any_q;
          out_slot_q <= any_q ? best_q[SLOT_W-1:0] : '0;
          out_t_q    <= any_q ? closest_q : '0;
          for (int i = 0; i < 3; i++) begin
            out_pt_q[i] <= any_q ? pt_q[i] : '0;
            out_nm_q[i] <= any_q ? nm_q[i] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign hit_slot_o  = out_slot_q;
  assign hit_t_o     = out_t_q;
  assign point_x_o   = out_pt_q[0];
  assign point_y_o   = out_pt_q[1];
  assign point_z_o   = out_pt_q[2];
  assign normal_x_o  = out_nm_q[0];
  assign normal_y_o  = out_nm_q[1];
  assign normal_z_o  = out_nm_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RSCH_ASSERT_NR(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")
  `RSCH_ASSERT(a_walk_bound, (state_q == S_RD) |-> (kk_q < n_q), "slot walk past count")
  `RSCH_ASSERT(a_closest_mono, (state_q != S_IDLE) |=> (state_q == S_IDLE || closest_q <= $past(closest_q)), "closest hit grew")
  `RSCH_ASSERT(a_out_load, (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE), "result not loaded")
  `RSCH_ASSERT(a_hit_t, (out_valid_o && hit_o) |-> (hit_t_o != '0), "hit with zero t")
  `RSCH_ASSERT(a_miss_zero, (out_valid_o && !hit_o) |-> (hit_slot_o == '0 && hit_t_o == '0 && point_x_o == '0), "miss word not cleared")

endmodule

// File: tb/sv/tb_ray_sphere_closest_hit_top.sv
`timescale 1ns / 1ps

module tb_ray_sphere_closest_hit_top;
  import rsch_pkg::*;

  localparam longint ONE      = 65536;          // 1.0 in Q16.16
  localparam longint CRD_MAX  = 64'h7FFF_FFFF;
  localparam longint CRD_MIN  = -64'sh8000_0000;
  localparam longint LIM_MAX  = 64'h7FFF_FFFF;
  localparam int     N_SLOTS  = MAX_SPHERES_DEF;
  localparam int     N_WORDS  = 1950;
  localparam int     STALL_LIMIT = 60000;       // cycles with no word moving on either side
  localparam int     DRAIN_GAP   = 400;         // one sphere pass plus the hit tail
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, write is dropped

  // one input word
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [CRD_W-1:0]  px, py, pz, dx, dy, dz;
    logic [RAD_W-1:0]  rad;
  } cast_word_t;

  // one result word
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [TLIM_W-1:0] t;
    logic [CRD_W-1:0]  px, py, pz, nx, ny, nz;
  } hit_word_t;

  typedef enum logic [1:0] {STEP_LOAD, STEP_RAY, STEP_REG} step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    cast_word_t           w;
    logic                 typed;   // expected result written out by hand
    hit_word_t            exp;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] val;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = MODE_LOAD;
  logic [SLOT_W-1:0]    slot_i = '0;
  logic signed [CRD_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [CRD_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [RAD_W-1:0]     sphere_radius_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [SLOT_W-1:0]    hit_slot_o;
  logic [TLIM_W-1:0]    hit_t_o;
  logic signed [CRD_W-1:0] point_x_o, point_y_o, point_z_o;
  logic signed [CRD_W-1:0] normal_x_o, normal_y_o, normal_z_o;

  ray_sphere_closest_hit_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i, .slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .dir_x_i, .dir_y_i, .dir_z_i, .sphere_radius_i,
    .out_valid_o, .out_ready_i, .hit_o, .hit_slot_o, .hit_t_o,
    .point_x_o, .point_y_o, .point_z_o, .normal_x_o, .normal_y_o, .normal_z_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state: sphere table and registers, updated as words are accepted.
  // ---------------------------------------------------------------------------
  longint    sph_ctr [N_SLOTS][3];
  longint    sph_rad [N_SLOTS];
  int        num_spheres = 0;
  longint    t_lo = 66;
  longint    t_hi = LIM_MAX;
  hit_word_t hits_due [$];
  int        n_errors = 0;
  int        in_idle_pct = 21;
  int        out_idle_pct = 55;
  int        words_sent = 0;

  function automatic longint clamp32(longint x);
    if (x > CRD_MAX) return CRD_MAX;
    if (x < CRD_MIN) return CRD_MIN;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Half-b quadratic against one slot; near root first, then far root,
  // each must fall strictly inside (lo, hi).
  function automatic bit try_sphere(int k, input longint o[3], input longint d[3],
                                    longint lo, longint hi, output longint t_hit);
    longint oc, big_a, big_b, big_c, a, b, c, disc, q, t;
    longint unsigned m, mx, mb, mc;
    int s;
    t_hit = 0;
    if (sph_rad[k] == 0) return 1'b0;
    big_a = 0;
    big_b = 0;
    big_c = 0;
    for (int i = 0; i < 3; i++) begin
      oc = o[i] - sph_ctr[k][i];
      m = (oc < 0) ? -oc : oc;
      big_a += (d[i] * d[i]) >>> 3;
      big_b += (oc * d[i]) >>> 3;
      big_c += longint'((m * m) >> 3);
    end
    big_c -= (sph_rad[k] * sph_rad[k]) >>> 3;
    mx = big_a;
    mb = (big_b < 0) ? -big_b : big_b;
    mc = (big_c < 0) ? -big_c : big_c;
    if (mb > mx) mx = mb;
    if (mc > mx) mx = mc;
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    a = big_a >>> s;
    b = big_b >>> s;
    c = big_c >>> s;
    if (a == 0) return 1'b0;
    disc = b * b - a * c;
    if (disc <= 0) return 1'b0;
    q = longint'(int_sqrt(disc));
    t = ((-b - q) * ONE) / a;
    if (t < hi && t > lo) begin
      t_hit = t;
      return 1'b1;
    end
    t = ((-b + q) * ONE) / a;
    if (t < hi && t > lo) begin
      t_hit = t;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Closest hit over the active slots for one ray word.
  function automatic hit_word_t closest_hit(cast_word_t w);
    longint o[3], d[3], pt[3], nm[3];
    longint closest, t;
    int n, best;
    bit any;
    hit_word_t r;
    o[0] = $signed(w.px); o[1] = $signed(w.py); o[2] = $signed(w.pz);
    d[0] = $signed(w.dx); d[1] = $signed(w.dy); d[2] = $signed(w.dz);
    n = (num_spheres > N_SLOTS) ? N_SLOTS : num_spheres;
    closest = t_hi;
    any = 1'b0;
    best = 0;
    for (int k = 0; k < n; k++) begin
      if (try_sphere(k, o, d, t_lo, closest, t)) begin
        any = 1'b1;
        closest = t;
        best = k;
      end
    end
    r = '0;
    if (!any) return r;
    for (int i = 0; i < 3; i++) begin
      pt[i] = clamp32(o[i] + ((closest * d[i]) >>> 16));
      nm[i] = clamp32(((pt[i] - sph_ctr[best][i]) * ONE) / sph_rad[best]);
    end
    r.hit  = 1'b1;
    r.slot = best[SLOT_W-1:0];
    r.t    = closest[TLIM_W-1:0];
    r.px = pt[0][31:0]; r.py = pt[1][31:0]; r.pz = pt[2][31:0];
    r.nx = nm[0][31:0]; r.ny = nm[1][31:0]; r.nz = nm[2][31:0];
    return r;
  endfunction

  task automatic report_err(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, compare against oldest expectation.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    hit_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hits_due.size() == 0) begin
        report_err("unexpected word", hit_o, 0);
      end else begin
        e = hits_due.pop_front();
        if (hit_o !== e.hit)          report_err("hit", hit_o, e.hit);
        if (hit_slot_o !== e.slot)    report_err("hit_slot", hit_slot_o, e.slot);
        if (hit_t_o !== e.t)          report_err("hit_t", hit_t_o, e.t);
        if (point_x_o !== e.px)       report_err("point_x", point_x_o, e.px);
        if (point_y_o !== e.py)       report_err("point_y", point_y_o, e.py);
        if (point_z_o !== e.pz)       report_err("point_z", point_z_o, e.pz);
        if (normal_x_o !== e.nx)      report_err("normal_x", normal_x_o, e.nx);
        if (normal_y_o !== e.ny)      report_err("normal_y", normal_y_o, e.ny);
        if (normal_z_o !== e.nz)      report_err("normal_z", normal_z_o, e.nz);
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long ends the run.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[ray_sphere_closest_hit_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Bookkeeping for an accepted word: loads update the table, rays queue a result.
  task automatic note_word(cast_word_t w, bit typed, hit_word_t exp);
    if (w.mode == MODE_LOAD) begin
      sph_ctr[w.slot][0] = $signed(w.px);
      sph_ctr[w.slot][1] = $signed(w.py);
      sph_ctr[w.slot][2] = $signed(w.pz);
      sph_rad[w.slot] = w.rad;
    end else begin
      hits_due.push_back(typed ? exp : closest_hit(w));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(cast_word_t w, bit typed = 1'b0, hit_word_t exp = '0);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    mode_i = w.mode;
    slot_i = w.slot;
    pos_x_i = w.px; pos_y_i = w.py; pos_z_i = w.pz;
    dir_x_i = w.dx; dir_y_i = w.dy; dir_z_i = w.dz;
    sphere_radius_i = w.rad;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    note_word(w, typed, exp);
    words_sent++;
    if (words_sent == N_WORDS / 3) begin
      in_idle_pct = 55;
      out_idle_pct = 21;
    end else if (words_sent == 2 * N_WORDS / 3) begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
    @(negedge clk_i);
  endtask

  // Wait for the block to go quiet, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (hits_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val[CFG_DAT_W-1:0];
    case (idx)
      REG_COUNT: num_spheres = int'(val & 64'h7F);
      REG_NEAR:  t_lo = val & LIM_MAX;
      REG_FAR:   t_hi = val & LIM_MAX;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic cast_word_t make_word(logic mode, int slot, longint x, longint y,
                                           longint z, longint dx, longint dy, longint dz,
                                           longint r);
    cast_word_t w;
    w.mode = mode;
    w.slot = slot[SLOT_W-1:0];
    w.px = x[31:0]; w.py = y[31:0]; w.pz = z[31:0];
    w.dx = dx[31:0]; w.dy = dy[31:0]; w.dz = dz[31:0];
    w.rad = r[RAD_W-1:0];
    return w;
  endfunction

  function automatic step_t load_step(int slot, longint x, longint y, longint z, longint r);
    step_t s;
    s = '0;
    s.kind = STEP_LOAD;
    s.w = make_word(MODE_LOAD, slot, x, y, z, 0, 0, 0, r);
    return s;
  endfunction

  function automatic step_t ray_step(longint x, longint y, longint z, longint dx,
                                     longint dy, longint dz, bit typed = 1'b0,
                                     hit_word_t exp = '0);
    step_t s;
    s = '0;
    s.kind = STEP_RAY;
    s.w = make_word(MODE_RAY, 0, x, y, z, dx, dy, dz, 0);
    s.typed = typed;
    s.exp = exp;
    return s;
  endfunction

  function automatic step_t reg_step(logic [CFG_IDX_W-1:0] idx, longint v);
    step_t s;
    s = '0;
    s.kind = STEP_REG;
    s.idx = idx;
    s.val = v[CFG_DAT_W-1:0];
    return s;
  endfunction

  // Well-formed sphere: center within +-30, radius 0.25 .. 6.
  function automatic cast_word_t rand_sphere(int slot);
    return make_word(MODE_LOAD, slot,
                     longint'($urandom_range(0, 60 * ONE)) - 30 * ONE,
                     longint'($urandom_range(0, 60 * ONE)) - 30 * ONE,
                     longint'($urandom_range(0, 60 * ONE)) - 30 * ONE,
                     $urandom, $urandom, $urandom,
                     $urandom_range(ONE / 4, 6 * ONE));
  endfunction

  function automatic cast_word_t rand_noise(logic mode);
    return make_word(mode, $urandom, $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom), $urandom);
  endfunction

  // Ray aimed near one of the active spheres, from a nearby origin.
  function automatic cast_word_t aimed_ray();
    longint o[3], tgt[3], d[3];
    int k, sh;
    k = $urandom_range(0, (num_spheres > 1 ? (num_spheres > N_SLOTS ? N_SLOTS :
                                                num_spheres) - 1 : 0));
    sh = $urandom_range(0, 6);
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'($urandom_range(0, 80 * ONE)) - 40 * ONE;
      tgt[i] = sph_ctr[k][i] + longint'($urandom_range(0, 2 * ONE)) - ONE;
      d[i] = (tgt[i] - o[i]) >>> sh;
    end
    return make_word(MODE_RAY, $urandom, o[0], o[1], o[2], d[0], d[1], d[2], $urandom);
  endfunction

  // Directed steps: empty table, a sphere hit dead on, zero direction, a miss,
  // zero radius, coordinate extremes, limits at both ends, unmapped register,
  // and an origin inside a sphere so only the far root counts.
  step_t steps [] = '{
    ray_step(0, 0, 0, 0, 0, ONE, 1'b1, '0),                   // no spheres active
    load_step(0, 0, 0, 5 * ONE, ONE),
    load_step(1, 0, 0, 10 * ONE, 2 * ONE),
    load_step(2, 0, 0, 3 * ONE, 0),                            // zero radius
    load_step(3, CRD_MAX, CRD_MAX, CRD_MAX, LIM_MAX),
    load_step(4, CRD_MIN, CRD_MIN, CRD_MIN, ONE),
    reg_step(REG_COUNT, 1),
    // straight along +z into unit sphere at 5: t = 4.0, normal (0,0,-1)
    ray_step(0, 0, 0, 0, 0, ONE, 1'b1,
             {1'b1, 6'd0, 31'd262144, 32'd0, 32'd0, 32'd262144,
              32'd0, 32'd0, 32'hFFFF_0000}),
    ray_step(0, 0, 0, 0, 0, 0, 1'b1, '0),                      // zero direction
    ray_step(0, 0, 0, ONE, 0, 0, 1'b1, '0),                    // discriminant negative
    reg_step(REG_COUNT, 5),
    ray_step(0, 0, 0, 0, 0, ONE),
    ray_step(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX),
    ray_step(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN),
    ray_step(0, 0, 0, CRD_MIN, CRD_MIN, CRD_MIN),
    ray_step(0, 0, 5 * ONE, 0, 0, ONE),                        // inside: far root
    reg_step(REG_NEAR, 0),
    reg_step(REG_FAR, 0),
    ray_step(0, 0, 0, 0, 0, ONE),
    reg_step(REG_NEAR, LIM_MAX),
    reg_step(REG_FAR, LIM_MAX),
    ray_step(0, 0, 20 * ONE, 0, 0, -ONE),
    reg_step(REG_SPARE, 7),
    reg_step(REG_NEAR, 66),
    ray_step(0, 0, 20 * ONE, 0, 0, -ONE)
  };

  initial begin
    int phase, quota, pick, r;
    @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      case (steps[i].kind)
        STEP_REG: write_reg(steps[i].idx, steps[i].val);
        default:  send_word(steps[i].w, steps[i].typed, steps[i].exp);
      endcase
    end

    // fill every slot so any count is legal from here on
    for (int k = 0; k < N_SLOTS; k++) send_word(rand_sphere(k));

    phase = 0;
    while (words_sent < N_WORDS) begin
      // register settings per phase; each write waits for an idle block,
      // which also makes the sender hold off until all results are back
      case (phase)
        3:       r = N_SLOTS;
        6:       r = 0;
        9:       r = 127;                                       // above table size
        default: r = $urandom_range(1, 4);
      endcase
      write_reg(REG_COUNT, r);
      if (phase % 4 == 1)      write_reg(REG_NEAR, 0);
      else if (phase == 7)     write_reg(REG_NEAR, LIM_MAX);
      else if (phase % 3 == 0) write_reg(REG_NEAR, 66);
      else                     write_reg(REG_NEAR, $urandom_range(0, ONE));
      if (phase == 5)          write_reg(REG_FAR, 0);
      else if (phase % 5 == 2) write_reg(REG_FAR, $urandom_range(ONE, 20 * ONE));
      else                     write_reg(REG_FAR, LIM_MAX);

      quota = (num_spheres > 8) ? 12 : 140;
      for (int j = 0; j < quota && words_sent < N_WORDS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 18)       send_word(rand_sphere($urandom_range(0, N_SLOTS - 1)));
        else if (pick < 22)  send_word(rand_noise(MODE_LOAD));
        else if (pick < 25)  send_word(make_word(MODE_LOAD, $urandom, 0, 0, 0,
                                                 0, 0, 0, 0));
        else if (pick < 82)  send_word(aimed_ray());
        else                 send_word(rand_noise(MODE_RAY));
      end
      phase++;
    end

    in_valid_i = 1'b0;
    while (hits_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("[ray_sphere_closest_hit_top] OK");
    end else begin
      $display("[ray_sphere_closest_hit_top] ERROR");
    end
    $finish;
  end

endmodule
